// ----- rtl/sdlp_pkg.sv -----
package sdlp_pkg;

    localparam int DATA_DEPTH_DEF     = 4096;
    localparam int WORD_BITS_DEF      = 15;
    localparam int MAX_LINE_WORDS_DEF = 64;

    localparam int WORD_W  = 15;
    localparam int ADDR_W  = 12;
    localparam int COUNT_W = 7;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_SYNTAX = 2'd1;
    localparam logic [1:0] ERR_RANGE  = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_start;
        logic       clear_address;
    } item_t;

    typedef struct packed {
        logic               word_valid;
        logic [WORD_W-1:0]  word;
        logic [ADDR_W-1:0]  address;
        logic               line_done;
        logic [COUNT_W-1:0] word_count;
        logic [1:0]         error_code;
    } result_t;

endpackage

// ----- rtl/signed_decimal_list_parser.sv -----
// Signed decimal list parser. Takes one character of a data-directive operand
// per request and returns at most one result per character: a number word with
// its data address, an end-of-line marker, or an error code (1 syntax, 2 range).
// A new character is accepted every cycle while the result side keeps up; each
// character passes an input register, then the phase update and a times-ten
// adder, then the result register. A result is presented once the edge that
// moves its request out of the input register has loaded the result register;
// a stalled held result delays that edge. While a held result is stalled no
// character leaves the input register, even one that gives no result, so the
// input side stalls once that register is full.
module signed_decimal_list_parser #(
    parameter int DATA_DEPTH     = sdlp_pkg::DATA_DEPTH_DEF,
    parameter int WORD_BITS      = sdlp_pkg::WORD_BITS_DEF,
    parameter int MAX_LINE_WORDS = sdlp_pkg::MAX_LINE_WORDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  sdlp_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_stall,
    output sdlp_pkg::result_t result
);

    localparam int AW = $clog2(DATA_DEPTH);
    localparam int CW = $clog2(MAX_LINE_WORDS + 1);
    localparam int PW = WORD_BITS + 4;

    localparam logic [2:0] PH_FIRST       = 3'd0;
    localparam logic [2:0] PH_AFTER_COMMA = 3'd1;
    localparam logic [2:0] PH_AFTER_SIGN  = 3'd2;
    localparam logic [2:0] PH_DIGITS      = 3'd3;
    localparam logic [2:0] PH_AFTER_NUM   = 3'd4;

    // input stage
    logic            in_valid_reg;
    sdlp_pkg::item_t in_reg;

    // parser state
    logic [2:0]           phase_reg, phase_next;
    logic                 neg_reg, neg_next;
    logic [WORD_BITS-1:0] mag_reg, mag_next;
    logic                 big_reg, big_next;
    logic [CW-1:0]        words_reg, words_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic                 failed_reg, failed_next;

    // result stage
    logic              out_valid_reg;
    sdlp_pkg::result_t out_reg;

    logic out_free;
    logic fire;

    logic                 r_valid;
    logic                 r_wv;
    logic [WORD_BITS-1:0] r_word;
    logic [AW-1:0]        r_addr;
    logic                 r_done;
    logic [CW-1:0]        r_count;
    logic [1:0]           r_err;

    logic [WORD_BITS+sdlp_pkg::WORD_W-1:0] word_wide;
    logic [AW+sdlp_pkg::ADDR_W-1:0]        addr_wide;
    logic [CW+sdlp_pkg::COUNT_W-1:0]       count_wide;
    sdlp_pkg::result_t                     res;

    logic [7:0]    ch;
    logic          is_nl, is_ws, is_digit, is_comma, is_sign;
    logic [3:0]    digit;
    logic [PW-1:0] prod;

    assign out_free   = !out_valid_reg || !result_stall;
    assign fire       = in_valid_reg && out_free;
    assign item_stall = in_valid_reg && !out_free;

    assign ch       = in_reg.ch;
    assign is_nl    = (ch == sdlp_pkg::CH_NL);
    assign is_ws    = (ch == sdlp_pkg::CH_SPACE) || (ch == sdlp_pkg::CH_TAB) ||
                      (ch == sdlp_pkg::CH_VT) || (ch == sdlp_pkg::CH_FF) ||
                      (ch == sdlp_pkg::CH_CR);
    assign is_digit = (ch >= sdlp_pkg::CH_ZERO) && (ch <= sdlp_pkg::CH_NINE);
    assign is_comma = (ch == sdlp_pkg::CH_COMMA);
    assign is_sign  = (ch == sdlp_pkg::CH_PLUS) || (ch == sdlp_pkg::CH_MINUS);
    assign digit    = 4'(ch - sdlp_pkg::CH_ZERO);

    always_comb
    begin
        logic [WORD_BITS-1:0] mag_base;
        logic                 ext_digit;
        logic                 line_clear;

        phase_next  = phase_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        big_next    = big_reg;
        words_next  = words_reg;
        addr_next   = addr_reg;
        failed_next = failed_reg;
        ext_digit   = 1'b0;
        line_clear  = 1'b0;

        r_valid = 1'b0;
        r_wv    = 1'b0;
        r_word  = '0;
        r_addr  = '0;
        r_done  = 1'b0;
        r_count = '0;
        r_err   = sdlp_pkg::ERR_NONE;

        if (in_reg.line_start)
        begin
            phase_next  = PH_FIRST;
            neg_next    = 1'b0;
            mag_next    = '0;
            big_next    = 1'b0;
            words_next  = '0;
            failed_next = 1'b0;
        end
        if (in_reg.clear_address)
        begin
            addr_next = '0;
        end

        if (failed_next)
        begin
            if (is_nl)
            begin
                line_clear = 1'b1;
            end
        end
        else if (!is_nl && !is_ws && !is_digit && !is_comma && !is_sign)
        begin
            failed_next = 1'b1;
            r_valid     = 1'b1;
            r_err       = sdlp_pkg::ERR_SYNTAX;
            r_count     = words_next;
        end
        else
        begin
            unique case (phase_next)
                PH_FIRST, PH_AFTER_COMMA:
                begin
                    if (is_ws)
                    begin
                    end
                    else if (is_nl)
                    begin
                        r_valid = 1'b1;
                        r_count = words_next;
                        if (phase_next == PH_AFTER_COMMA)
                        begin
                            failed_next = 1'b1;
                            r_err       = sdlp_pkg::ERR_SYNTAX;
                        end
                        else
                        begin
                            r_done     = 1'b1;
                            line_clear = 1'b1;
                        end
                    end
                    else if (is_comma)
                    begin
                        failed_next = 1'b1;
                        r_valid     = 1'b1;
                        r_err       = sdlp_pkg::ERR_SYNTAX;
                        r_count     = words_next;
                    end
                    else
                    begin
                        neg_next = 1'b0;
                        mag_next = '0;
                        big_next = 1'b0;
                        if (is_sign)
                        begin
                            neg_next   = (ch == sdlp_pkg::CH_MINUS);
                            phase_next = PH_AFTER_SIGN;
                        end
                        else
                        begin
                            ext_digit = 1'b1;
                        end
                    end
                end
                PH_AFTER_SIGN:
                begin
                    if (!is_digit)
                    begin
                        failed_next = 1'b1;
                        r_valid     = 1'b1;
                        r_err       = sdlp_pkg::ERR_SYNTAX;
                        r_count     = words_next;
                    end
                    else
                    begin
                        ext_digit = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        ext_digit = 1'b1;
                    end
                    else if (is_sign)
                    begin
                        failed_next = 1'b1;
                        r_valid     = 1'b1;
                        r_err       = sdlp_pkg::ERR_SYNTAX;
                        r_count     = words_next;
                    end
                    else if (!neg_next && big_next)
                    begin
                        failed_next = 1'b1;
                        r_valid     = 1'b1;
                        r_err       = sdlp_pkg::ERR_RANGE;
                        r_count     = words_next;
                    end
                    else if (words_next >= CW'(MAX_LINE_WORDS))
                    begin
                        failed_next = 1'b1;
                        r_valid     = 1'b1;
                        r_err       = sdlp_pkg::ERR_SYNTAX;
                        r_count     = words_next;
                    end
                    else
                    begin
                        r_valid = 1'b1;
                        r_wv    = 1'b1;
                        r_word  = neg_next ? (WORD_BITS'(0) - mag_next) : mag_next;
                        r_addr  = addr_next;
                        if (addr_next == AW'(DATA_DEPTH - 1))
                        begin
                            addr_next = '0;
                        end
                        else
                        begin
                            addr_next = addr_next + 1'b1;
                        end
                        words_next = words_next + 1'b1;
                        r_count    = words_next;
                        neg_next   = 1'b0;
                        mag_next   = '0;
                        big_next   = 1'b0;
                        if (is_nl)
                        begin
                            r_done     = 1'b1;
                            line_clear = 1'b1;
                        end
                        else
                        begin
                            phase_next = is_comma ? PH_AFTER_COMMA : PH_AFTER_NUM;
                        end
                    end
                end
                default:
                begin
                    if (is_ws)
                    begin
                    end
                    else if (is_comma)
                    begin
                        phase_next = PH_AFTER_COMMA;
                    end
                    else if (is_nl)
                    begin
                        r_valid    = 1'b1;
                        r_done     = 1'b1;
                        r_count    = words_next;
                        line_clear = 1'b1;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                        r_valid     = 1'b1;
                        r_err       = sdlp_pkg::ERR_SYNTAX;
                        r_count     = words_next;
                    end
                end
            endcase
        end

        // times ten plus digit; any carry past the word marks the number too big
        mag_base = mag_next;
        prod     = ({4'b0, mag_base} << 3) + ({4'b0, mag_base} << 1) + PW'(digit);
        if (ext_digit)
        begin
            if (|prod[PW-1:WORD_BITS])
            begin
                big_next = 1'b1;
            end
            mag_next   = prod[WORD_BITS-1:0];
            phase_next = PH_DIGITS;
        end

        if (line_clear)
        begin
            phase_next  = PH_FIRST;
            neg_next    = 1'b0;
            mag_next    = '0;
            big_next    = 1'b0;
            words_next  = '0;
            failed_next = 1'b0;
        end
    end

    assign word_wide  = {{sdlp_pkg::WORD_W{1'b0}}, r_word};
    assign addr_wide  = {{sdlp_pkg::ADDR_W{1'b0}}, r_addr};
    assign count_wide = {{sdlp_pkg::COUNT_W{1'b0}}, r_count};

    always_comb
    begin
        res.word_valid = r_wv;
        res.word       = word_wide[sdlp_pkg::WORD_W-1:0];
        res.address    = addr_wide[sdlp_pkg::ADDR_W-1:0];
        res.line_done  = r_done;
        res.word_count = count_wide[sdlp_pkg::COUNT_W-1:0];
        res.error_code = r_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_FIRST;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            big_reg       <= 1'b0;
            words_reg     <= '0;
            addr_reg      <= '0;
            failed_reg    <= 1'b0;
        end
        else
        begin
            if (!item_stall)
            begin
                in_valid_reg <= item_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= fire && r_valid;
            end
            if (fire)
            begin
                phase_reg  <= phase_next;
                neg_reg    <= neg_next;
                mag_reg    <= mag_next;
                big_reg    <= big_next;
                words_reg  <= words_next;
                addr_reg   <= addr_next;
                failed_reg <= failed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            in_reg <= item;
        end
        if (fire && r_valid)
        begin
            out_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTH
    a_word_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.word_valid |-> result.error_code == sdlp_pkg::ERR_NONE)
        else $error("word emitted together with an error");

    a_done_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.line_done |-> result.error_code == sdlp_pkg::ERR_NONE)
        else $error("line ended cleanly with an error code");

    a_result_meaningful: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.word_valid || result.line_done ||
                         result.error_code != sdlp_pkg::ERR_NONE)
        else $error("empty result delivered");

    a_words_bound: assert property (@(posedge clk) disable iff (!rst_n)
        words_reg <= CW'(MAX_LINE_WORDS))
        else $error("line word count past limit");

    a_failed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fire && failed_reg && !in_reg.line_start |=> !result_valid)
        else $error("result after a line error");
`endif

endmodule

// ----- bench/tb_signed_decimal_list_parser.sv -----
module tb_signed_decimal_list_parser;
    import sdlp_pkg::*;

    localparam logic [7:0] WS_CODES [5] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};

    typedef enum logic [2:0] {
        EXPECT_FIRST,
        EXPECT_NEXT,
        AFTER_SIGN,
        IN_DIGITS,
        AFTER_NUMBER
    } parse_phase_e;

    // Predicts the parser's result for each accepted request and checks
    // the results coming back in order.
    class list_scoreboard;
        parse_phase_e       phase = EXPECT_FIRST;
        bit                 negative;
        logic [WORD_W-1:0]  magnitude = '0;
        bit                 too_big;
        logic [COUNT_W-1:0] line_words = '0;
        logic [ADDR_W-1:0]  next_address = '0;
        bit                 line_failed;
        bit                 wrapped;
        result_t            pending_results[$];
        int mismatches, checked, words, lines_done, syntax_errs, range_errs;

        function int pending();
            return pending_results.size();
        endfunction

        function void clear_line();
            phase = EXPECT_FIRST;
            negative = 0;
            magnitude = '0;
            too_big = 0;
            line_words = '0;
            line_failed = 0;
        endfunction

        function void queue_result(bit valid, logic [WORD_W-1:0] w, logic [ADDR_W-1:0] a,
                                   bit done, logic [1:0] err);
            result_t r;
            r.word_valid = valid;
            r.word = w;
            r.address = a;
            r.line_done = done;
            r.word_count = line_words;
            r.error_code = err;
            pending_results.push_back(r);
            words += valid;
            lines_done += done;
            syntax_errs += (err == ERR_SYNTAX);
            range_errs += (err == ERR_RANGE);
        endfunction

        function void fail(logic [1:0] err);
            line_failed = 1;
            queue_result(0, '0, '0, 0, err);
        endfunction

        function logic [1:0] close_number(output logic [WORD_W-1:0] w,
                                          output logic [ADDR_W-1:0] a);
            w = '0;
            a = '0;
            if (!negative && too_big)
                return ERR_RANGE;
            if (line_words >= MAX_LINE_WORDS_DEF)
                return ERR_SYNTAX;
            w = negative ? WORD_W'('0 - magnitude) : magnitude;
            a = next_address;
            if (next_address == '1)
                wrapped = 1;
            next_address = next_address + 1'b1;
            line_words = line_words + 1'b1;
            negative = 0;
            magnitude = '0;
            too_big = 0;
            return ERR_NONE;
        endfunction

        function void take_request(item_t it);
            logic [7:0]        c;
            bit                nl, ws, dig, comma, sgn;
            logic [WORD_W-1:0] w;
            logic [ADDR_W-1:0] a;
            logic [1:0]        err;
            int                nv;
            c = it.ch;
            if (it.line_start)
                clear_line();
            if (it.clear_address)
                next_address = '0;
            nl = (c == CH_NL);
            ws = (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR);
            dig = (c >= CH_ZERO && c <= CH_NINE);
            comma = (c == CH_COMMA);
            sgn = (c == CH_PLUS || c == CH_MINUS);

            // a failed line swallows everything up to its newline
            if (line_failed)
            begin
                if (nl)
                    clear_line();
                return;
            end
            if (!(nl || ws || dig || comma || sgn))
            begin
                fail(ERR_SYNTAX);
                return;
            end

            case (phase)
                EXPECT_FIRST, EXPECT_NEXT:
                begin
                    if (ws)
                        return;
                    if (nl)
                    begin
                        if (phase == EXPECT_NEXT)
                            fail(ERR_SYNTAX);
                        else
                        begin
                            queue_result(0, '0, '0, 1, ERR_NONE);
                            clear_line();
                        end
                        return;
                    end
                    if (comma)
                    begin
                        fail(ERR_SYNTAX);
                        return;
                    end
                    negative = 0;
                    magnitude = '0;
                    too_big = 0;
                    if (sgn)
                    begin
                        negative = (c == CH_MINUS);
                        phase = AFTER_SIGN;
                        return;
                    end
                end
                AFTER_SIGN:
                begin
                    if (!dig)
                    begin
                        fail(ERR_SYNTAX);
                        return;
                    end
                end
                IN_DIGITS:
                begin
                    if (!dig)
                    begin
                        if (sgn)
                        begin
                            fail(ERR_SYNTAX);
                            return;
                        end
                        err = close_number(w, a);
                        if (err != ERR_NONE)
                        begin
                            fail(err);
                            return;
                        end
                        if (nl)
                        begin
                            queue_result(1, w, a, 1, ERR_NONE);
                            clear_line();
                            return;
                        end
                        phase = comma ? EXPECT_NEXT : AFTER_NUMBER;
                        queue_result(1, w, a, 0, ERR_NONE);
                        return;
                    end
                end
                default:
                begin
                    if (ws)
                        return;
                    if (comma)
                    begin
                        phase = EXPECT_NEXT;
                        return;
                    end
                    if (nl)
                    begin
                        queue_result(0, '0, '0, 1, ERR_NONE);
                        clear_line();
                        return;
                    end
                    fail(ERR_SYNTAX);
                    return;
                end
            endcase

            // digit: times ten plus digit, overflow only remembered
            nv = int'(magnitude) * 10 + int'(c) - int'(CH_ZERO);
            if (nv > (1 << WORD_W) - 1)
                too_big = 1;
            magnitude = WORD_W'(nv);
            phase = IN_DIGITS;
        endfunction

        function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (want_v !== got_v)
            begin
                mismatches++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, want_v, got_v);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("word_valid", want.word_valid, got.word_valid);
            compare_field("word", want.word, got.word);
            compare_field("address", want.address, got.address);
            compare_field("line_done", want.line_done, got.line_done);
            compare_field("word_count", want.word_count, got.word_count);
            compare_field("error_code", want.error_code, got.error_code);
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    list_scoreboard sb;
    logic [7:0]     line_q[$];
    int             items_sent;
    int             lines;
    bit             quiet;
    bit             send_calm;
    bit             recv_calm;
    int             hold_left;
    int             burst_left;
    int             cycle_count;

    signed_decimal_list_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: check, then choose the stall for the next cycle.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count % 50 == 0)
            recv_calm = ($urandom_range(0, 3) == 0);
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(result);
            if (sb.checked == 100)
                hold_left = 60;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
            result_stall <= 1'b1;
        end
        else if (!quiet && !recv_calm && $urandom_range(0, 5) == 0)
        begin
            burst_left = $urandom_range(0, 4);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endfunction

    function automatic void add_ws();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n)
            line_q.push_back(WS_CODES[$urandom_range(0, 4)]);
    endfunction

    // Well-formed list of count numbers ending in newline.
    function automatic void add_list(int count, bit digits_only);
        string s;
        int    v;
        for (int k = 0; k < count; k++)
        begin
            if (k > 0)
            begin
                if (!digits_only)
                    add_ws();
                line_q.push_back(CH_COMMA);
            end
            if (!digits_only)
                add_ws();
            case ($urandom_range(0, 3))
                0: line_q.push_back(CH_MINUS);
                1: line_q.push_back(CH_PLUS);
                default: ;
            endcase
            if (digits_only)
                v = $urandom_range(0, 9);
            else
                case ($urandom_range(0, 5))
                    0: v = $urandom_range(0, 9);
                    1: v = $urandom_range(0, 32767);
                    2: v = $urandom_range(32760, 32775);
                    3: v = $urandom_range(0, 999999);
                    4: v = int'($urandom_range(0, 2000000000));
                    default: v = $urandom_range(0, 99);
                endcase
            s = $sformatf("%0d", v);
            if (!digits_only && $urandom_range(0, 7) == 0)
                s = {"00", s};
            add_text(s);
        end
        if (!digits_only)
            add_ws();
        line_q.push_back(CH_NL);
    endfunction

    task automatic send_request(input item_t it);
        if (!quiet && !send_calm && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (item_stall);
        sb.take_request(it);
        items_sent++;
    endtask

    task automatic send_line(input bit first_start, input bit first_clear, input bit scatter);
        item_t it;
        foreach (line_q[i])
        begin
            it.ch = line_q[i];
            it.line_start = (i == 0) ? first_start : (scatter && $urandom_range(0, 39) == 0);
            it.clear_address = (i == 0) ? first_clear
                                        : (scatter && $urandom_range(0, 59) == 0);
            send_request(it);
        end
        line_q.delete();
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        int pick;
        int drain_cycles;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty line, extremes, negative wrap, range error, trailing comma, bad char
        add_text("\n");
        send_line(1'b1, 1'b1, 1'b0);
        add_text("32767,-65537\n");
        send_line(1'b1, 1'b0, 1'b0);
        add_text("40000\n");
        send_line(1'b1, 1'b0, 1'b0);
        add_text("1,\n");
        send_line(1'b1, 1'b0, 1'b0);
        add_text("x\n");
        send_line(1'b1, 1'b0, 1'b0);
        wait_drained();

        while (items_sent < 1000)
        begin
            lines++;
            send_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                add_ws();
                line_q.push_back(CH_NL);
            end
            else if (pick < 15)
            begin
                repeat ($urandom_range(1, 10))
                    line_q.push_back(8'($urandom_range(0, 255)));
                line_q.push_back(CH_NL);
            end
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    add_list($urandom_range(63, 66), 1'b1);
                else
                    add_list($urandom_range(1, 6), 1'b0);
                // broken lines
                if (pick >= 80)
                    case ($urandom_range(0, 5))
                        0: line_q.insert($urandom_range(0, line_q.size() - 1),
                                         8'($urandom_range(0, 255)));
                        1: line_q.insert($urandom_range(0, line_q.size() - 1), CH_COMMA);
                        2: line_q.insert($urandom_range(0, line_q.size() - 1),
                                         $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                        3: line_q.delete($urandom_range(0, line_q.size() - 2));
                        4: line_q.insert($urandom_range(0, line_q.size() - 1), CH_SPACE);
                        default: void'(line_q.pop_back()); // runs on into the next line
                    endcase
            end
            send_line($urandom_range(0, 7) != 0, 1'b0, 1'b1);
            if (lines == 15)
                wait_drained();
        end

        // two full lines from address zero, no idling on either side
        quiet = 1'b1;
        for (int n = 0; n < 2; n++)
        begin
            add_list(MAX_LINE_WORDS_DEF, 1'b1);
            send_line(1'b1, n == 0, 1'b0);
        end

        item_valid <= 1'b0;
        drain_cycles = 0;
        while (sb.pending() != 0 && drain_cycles < 10000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (20) @(posedge clk);

        if (sb.pending() != 0)
            $display("%0t: %0d results missing: expected %h, actual none",
                     $time, sb.pending(), sb.pending_results[0]);
        $display("Sent %0d characters (%0d random lines), checked %0d results: %0d words,",
                 items_sent, lines, sb.checked, sb.words);
        $display("  %0d lines closed, %0d syntax and %0d range errors, address wrap %s",
                 sb.lines_done, sb.syntax_errs, sb.range_errs,
                 sb.wrapped ? "reached" : "not reached");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("%0t: timeout, %0d results outstanding", $time, sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
